// ===== hdl/sva_pkg.sv =====
package sva_pkg;

    localparam int FRAME_BITS  = 13;
    localparam int ITEM_BITS   = 13;
    localparam int POS_BITS    = 12;
    localparam int ROWIDX_BITS = 4;
    localparam int COUNT_BITS  = 8;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd1080;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        STEP_WAIT,
        STEP_DISPATCH,
        STEP_SCAN,
        STEP_RESOLVE,
        STEP_NEWROW,
        STEP_PLACE,
        STEP_CLEAR,
        STEP_FAIL
    } t_step;

    typedef enum logic [2:0] {
        COND_IN_ACC,
        COND_IS_CLEAR,
        COND_SCAN_DONE,
        COND_ROW_END,
        COND_NEW_OK,
        COND_OUT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ADVANCE,
        ACT_OPEN,
        ACT_COMMIT,
        ACT_CLEAR,
        ACT_FAIL
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_step tgt_true;
        t_step tgt_false;
        t_act  act;
        logic  act_on_true;
    } t_uword;

    // control store: one word per step
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            STEP_WAIT:     w = '{COND_IN_ACC,    STEP_DISPATCH, STEP_WAIT,
                                 ACT_LOAD,    1'b1};
            STEP_DISPATCH: w = '{COND_IS_CLEAR,  STEP_CLEAR,    STEP_SCAN,
                                 ACT_NONE,    1'b1};
            STEP_SCAN:     w = '{COND_SCAN_DONE, STEP_RESOLVE,  STEP_SCAN,
                                 ACT_ADVANCE, 1'b0};
            STEP_RESOLVE:  w = '{COND_ROW_END,   STEP_NEWROW,   STEP_PLACE,
                                 ACT_NONE,    1'b1};
            STEP_NEWROW:   w = '{COND_NEW_OK,    STEP_PLACE,    STEP_FAIL,
                                 ACT_OPEN,    1'b1};
            STEP_PLACE:    w = '{COND_OUT_FREE,  STEP_WAIT,     STEP_PLACE,
                                 ACT_COMMIT,  1'b1};
            STEP_CLEAR:    w = '{COND_OUT_FREE,  STEP_WAIT,     STEP_CLEAR,
                                 ACT_CLEAR,   1'b1};
            STEP_FAIL:     w = '{COND_OUT_FREE,  STEP_WAIT,     STEP_FAIL,
                                 ACT_FAIL,    1'b1};
            default:       w = '{COND_IN_ACC,    STEP_WAIT,     STEP_WAIT,
                                 ACT_NONE,    1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/sva_req_if.sv =====
interface sva_req_if;
    import sva_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ITEM_BITS-1:0] item_width;
    logic [ITEM_BITS-1:0] item_height;

    modport source(output valid, req_type, item_width, item_height, input ready);
    modport sink(input valid, req_type, item_width, item_height, output ready);
endinterface

// ===== hdl/sva_res_if.sv =====
interface sva_res_if;
    import sva_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   placed;
    logic [POS_BITS-1:0]    pos_x;
    logic [POS_BITS-1:0]    pos_y;
    logic [ROWIDX_BITS-1:0] row_index;
    logic [COUNT_BITS-1:0]  member_total;

    modport source(output valid, placed, pos_x, pos_y, row_index, member_total,
                   input ready);
    modport sink(input valid, placed, pos_x, pos_y, row_index, member_total,
                 output ready);
endinterface

// ===== hdl/sva_ram.sv =====
module sva_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hdl/shelf_viewport_allocator.sv =====
// Shelf packer: places rectangles row by row into a frame of frame_width by
// frame_height pixels and returns one result beat per request beat. A small
// microcoded sequencer scans the open rows, one row-table read per cycle. A
// rectangle passes through dispatch, the row scan, resolve, a new row when no
// open row fits, and the place step, or the fail step when no row can be
// opened; a clear passes through dispatch and the clear step. The row table
// is not cleared after reset and needs no sweep; only rows below the open-row
// count are ever used. Requests are taken one at a time; a finished result
// sits in an output register while the next request is accepted. Write the
// frame registers only while the block is idle.
module shelf_viewport_allocator #(
    parameter int MAX_ROWS   = 16,
    parameter int COORD_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sva_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [sva_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    sva_req_if.sink                           i_req,
    sva_res_if.source                         o_res
);
    import sva_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int WB = ((COORD_BITS > ITEM_BITS) ? COORD_BITS : ITEM_BITS) + 2;
    localparam int DW = 3 * COORD_BITS;

    t_step r_step, n_step;
    t_uword uw;

    logic [FRAME_BITS-1:0] r_frame_w, r_frame_h;
    logic                  r_type;
    logic [ITEM_BITS-1:0]  r_w, r_h;
    logic [RW-1:0]         r_row, n_row;
    logic [RW-1:0]         r_rows_used, n_rows_used;
    logic [COUNT_BITS-1:0] r_members, n_members;
    logic [COORD_BITS:0]   r_last_end_y, n_last_end_y;
    logic                  r_fresh, n_fresh;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_placed, n_out_placed;
    logic [POS_BITS-1:0]    r_out_x, n_out_x;
    logic [POS_BITS-1:0]    r_out_y, n_out_y;
    logic [ROWIDX_BITS-1:0] r_out_row, n_out_row;
    logic [COUNT_BITS-1:0]  r_out_total, n_out_total;

    logic [DW-1:0]         rd_data, wr_data;
    logic [COORD_BITS-1:0] rd_end, rd_start, rd_height;
    logic [COORD_BITS-1:0] base_end, base_start, base_height;
    logic [COORD_BITS-1:0] new_end, new_height;
    logic                  wr_en;

    logic in_acc, out_free, row_end, is_last, fit, new_ok, cond_val, fire;
    logic [COUNT_BITS-1:0] members_inc;

    assign i_req.ready = (r_step == STEP_WAIT);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign {rd_end, rd_start, rd_height} = rd_data;

    assign row_end = (r_row == r_rows_used);
    assign is_last = (RW'(r_row + RW'(1)) == r_rows_used);
    assign fit = (WB'(rd_end) + WB'(r_w) <= WB'(r_frame_w)) &&
                 (is_last ? (WB'(r_h) + WB'(rd_start) <= WB'(r_frame_h))
                          : (WB'(r_h) <= WB'(rd_height)));
    assign new_ok = (r_rows_used < RW'(MAX_ROWS)) &&
                    (WB'(r_w) <= WB'(r_frame_w)) &&
                    (WB'(r_h) + WB'(r_last_end_y) <= WB'(r_frame_h));

    // a freshly opened row starts empty at the previous row's end Y
    assign base_end    = r_fresh ? '0 : rd_end;
    assign base_start  = r_fresh ? r_last_end_y[COORD_BITS-1:0] : rd_start;
    assign base_height = r_fresh ? '0 : rd_height;
    assign new_end     = COORD_BITS'(WB'(base_end) + WB'(r_w));
    assign new_height  = (WB'(r_h) > WB'(base_height)) ? COORD_BITS'(r_h)
                                                      : base_height;
    assign wr_data     = {new_end, base_start, new_height};
    assign members_inc = (r_members < COUNT_MAX) ? r_members + 1'b1 : r_members;

    always_comb begin
        uw = ucode(r_step);
        case (uw.cond)
            COND_IN_ACC:    cond_val = in_acc;
            COND_IS_CLEAR:  cond_val = (r_type == REQ_CLEAR);
            COND_SCAN_DONE: cond_val = row_end || fit;
            COND_ROW_END:   cond_val = row_end;
            COND_NEW_OK:    cond_val = new_ok;
            COND_OUT_FREE:  cond_val = out_free;
            default:        cond_val = 1'b0;
        endcase
        fire   = (cond_val == uw.act_on_true);
        n_step = cond_val ? uw.tgt_true : uw.tgt_false;

        n_row        = r_row;
        n_rows_used  = r_rows_used;
        n_members    = r_members;
        n_last_end_y = r_last_end_y;
        n_fresh      = r_fresh;
        wr_en        = 1'b0;

        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_placed = r_out_placed;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_row    = r_out_row;
        n_out_total  = r_out_total;

        if (r_step == STEP_WAIT) begin
            n_row = '0;
        end

        if (fire) begin
            case (uw.act)
                ACT_LOAD: begin
                    n_last_end_y = '0;
                    n_fresh      = 1'b0;
                end
                ACT_ADVANCE: begin
                    n_row        = RW'(r_row + RW'(1));
                    n_last_end_y = (COORD_BITS + 1)'(rd_start) +
                                   (COORD_BITS + 1)'(rd_height);
                end
                ACT_OPEN: begin
                    n_rows_used = RW'(r_rows_used + RW'(1));
                    n_fresh     = 1'b1;
                end
                ACT_COMMIT: begin
                    wr_en        = 1'b1;
                    n_members    = members_inc;
                    n_out_valid  = 1'b1;
                    n_out_placed = 1'b1;
                    n_out_x      = POS_BITS'(base_end);
                    n_out_y      = POS_BITS'(base_start);
                    n_out_row    = ROWIDX_BITS'(r_row);
                    n_out_total  = members_inc;
                end
                ACT_CLEAR: begin
                    n_rows_used  = '0;
                    n_members    = '0;
                    n_out_valid  = 1'b1;
                    n_out_placed = 1'b0;
                    n_out_x      = '0;
                    n_out_y      = '0;
                    n_out_row    = '0;
                    n_out_total  = '0;
                end
                ACT_FAIL: begin
                    n_out_valid  = 1'b1;
                    n_out_placed = 1'b0;
                    n_out_x      = '0;
                    n_out_y      = '0;
                    n_out_row    = '0;
                    n_out_total  = r_members;
                end
                default: begin
                end
            endcase
        end
    end

    // read address follows the next row so the table output tracks r_row
    sva_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_row[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_WAIT;
            r_frame_w   <= FRAME_WIDTH_RST;
            r_frame_h   <= FRAME_HEIGHT_RST;
            r_rows_used <= '0;
            r_members   <= '0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_fresh     <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_rows_used <= n_rows_used;
            r_members   <= n_members;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_fresh     <= n_fresh;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type <= i_req.req_type;
            r_w    <= i_req.item_width;
            r_h    <= i_req.item_height;
        end
        r_last_end_y <= n_last_end_y;
        r_out_placed <= n_out_placed;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_row    <= n_out_row;
        r_out_total  <= n_out_total;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.placed       = r_out_placed;
    assign o_res.pos_x        = r_out_x;
    assign o_res.pos_y        = r_out_y;
    assign o_res.row_index    = r_out_row;
    assign o_res.member_total = r_out_total;

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_used <= RW'(MAX_ROWS))
        else $error("open row count beyond table depth");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_step == STEP_DISPATCH))
        else $error("accepted beat not dispatched");

    a_placed_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.placed) |-> (o_res.member_total != '0))
        else $error("placed beat with zero member total");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_SCAN) |-> (r_row <= r_rows_used))
        else $error("row scan ran past the open rows");
endmodule

// ===== tb/sv/shelf_viewport_allocator_tb.sv =====
module shelf_viewport_allocator_tb;
    import sva_pkg::*;

    localparam int SHELF_SLOTS = 16;
    localparam int IDLE_PCT    = 28;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int ITEM_TARGET = 750;

    typedef struct packed {
        logic                   placed;
        logic [POS_BITS-1:0]    pos_x;
        logic [POS_BITS-1:0]    pos_y;
        logic [ROWIDX_BITS-1:0] row_index;
        logic [COUNT_BITS-1:0]  member_total;
    } t_placement;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    sva_req_if req_if ();
    sva_res_if res_if ();

    shelf_viewport_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always #2 i_clk = ~i_clk;

    // shelf table as the block should hold it
    logic [FRAME_BITS-1:0] frame_w = FRAME_WIDTH_RST;
    logic [FRAME_BITS-1:0] frame_h = FRAME_HEIGHT_RST;
    logic [ITEM_BITS-1:0]  shelf_end_x [SHELF_SLOTS];
    logic [ITEM_BITS-1:0]  shelf_top_y [SHELF_SLOTS];
    logic [ITEM_BITS-1:0]  shelf_tall  [SHELF_SLOTS];
    int                    shelves_open = 0;
    logic [COUNT_BITS-1:0] placed_count = '0;

    t_placement pending_placements[$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         gaps_on     = 1'b1;

    function automatic void add_member(input int r, input logic [ITEM_BITS-1:0] w,
                                       input logic [ITEM_BITS-1:0] h);
        shelf_end_x[r] = shelf_end_x[r] + w;
        if (h > shelf_tall[r])
            shelf_tall[r] = h;
        if (placed_count != COUNT_MAX)
            placed_count = placed_count + 1'b1;
    endfunction

    function automatic t_placement predict_placement(input logic kind,
                                                     input logic [ITEM_BITS-1:0] w,
                                                     input logic [ITEM_BITS-1:0] h);
        t_placement res;
        int room_w, room_h, shelf_floor, r;
        res = '0;
        shelf_floor = 0;
        if (kind == REQ_CLEAR) begin
            shelves_open = 0;
            placed_count = '0;
            return res;
        end
        for (r = 0; r < shelves_open; r++) begin
            room_w = int'(frame_w) - int'(shelf_end_x[r]);
            // the last open row may grow down to the frame bottom
            room_h = (r + 1 == shelves_open) ? int'(frame_h) - int'(shelf_top_y[r])
                                             : int'(shelf_tall[r]);
            if (int'(w) <= room_w && int'(h) <= room_h) begin
                res.placed    = 1'b1;
                res.pos_x     = shelf_end_x[r][POS_BITS-1:0];
                res.pos_y     = shelf_top_y[r][POS_BITS-1:0];
                res.row_index = r[ROWIDX_BITS-1:0];
                add_member(r, w, h);
                res.member_total = placed_count;
                return res;
            end
            shelf_floor = int'(shelf_top_y[r]) + int'(shelf_tall[r]);
        end
        if (shelves_open < SHELF_SLOTS && int'(w) <= int'(frame_w) &&
            int'(h) <= int'(frame_h) - shelf_floor) begin
            r = shelves_open;
            shelf_end_x[r] = '0;
            shelf_top_y[r] = shelf_floor[ITEM_BITS-1:0];
            shelf_tall[r]  = '0;
            shelves_open++;
            add_member(r, w, h);
            res.placed    = 1'b1;
            res.pos_y     = shelf_top_y[r][POS_BITS-1:0];
            res.row_index = r[ROWIDX_BITS-1:0];
        end
        res.member_total = placed_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        res_if.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result beat: ",
                              "placed=%0d x=%0d y=%0d row=%0d total=%0d"},
                             res_if.placed, res_if.pos_x, res_if.pos_y,
                             res_if.row_index, res_if.member_total);
            end else begin
                want = pending_placements.pop_front();
                if (res_if.placed !== want.placed || res_if.pos_x !== want.pos_x ||
                    res_if.pos_y !== want.pos_y || res_if.row_index !== want.row_index ||
                    res_if.member_total !== want.member_total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: ",
                                  "exp placed=%0d x=%0d y=%0d row=%0d total=%0d, ",
                                  "got placed=%0d x=%0d y=%0d row=%0d total=%0d"},
                                 want.placed, want.pos_x, want.pos_y, want.row_index,
                                 want.member_total, res_if.placed, res_if.pos_x,
                                 res_if.pos_y, res_if.row_index, res_if.member_total);
                end
            end
        end
    end

    task automatic send_request(input logic kind, input logic [ITEM_BITS-1:0] w,
                                input logic [ITEM_BITS-1:0] h);
        t_placement exp_beat;
        if (gaps_on)
            while ($urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.item_width  <= w;
        req_if.item_height <= h;
        do
            @(posedge i_clk);
        while (req_if.ready !== 1'b1);
        exp_beat = predict_placement(kind, w, h);
        pending_placements.insert(pending_placements.size(), exp_beat);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frame(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            frame_w = value;
        else
            frame_h = value;
    endtask

    task automatic set_frame(input int fw, input int fh);
        write_frame(CFG_FRAME_WIDTH, CFG_DATA_BITS'(fw));
        write_frame(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(fh));
    endtask

    task automatic test_reset_frame();
        send_request(REQ_PLACE, 0, 0);
        send_request(REQ_PLACE, 1920, 100);
        send_request(REQ_PLACE, 1, 1);
        send_request(REQ_PLACE, 0, 0);
        send_request(REQ_PLACE, 100, 200);
        send_request(REQ_PLACE, 10, 981);
        send_request(REQ_PLACE, 4096, 1);
        send_request(REQ_PLACE, 13'h1FFF, 13'h1FFF);
        send_request(REQ_CLEAR, 13'h1FFF, 13'h1FFF);
    endtask

    // one-pixel-wide frame: every item opens a row until the slots run out
    task automatic test_row_slots();
        set_frame(1, 4096);
        send_request(REQ_CLEAR, 0, 0);
        repeat (SHELF_SLOTS + 1)
            send_request(REQ_PLACE, 1, 1);
    endtask

    // rows stay put when the frame shrinks underneath them
    task automatic test_frame_shrink();
        set_frame(4096, 1);
        send_request(REQ_PLACE, 0, 0);
        send_request(REQ_PLACE, 1, 2);
        send_request(REQ_PLACE, 4095, 1);
    endtask

    task automatic test_random_mix();
        int sent, phase, burst, clear_pct, fw, fh, span_w, span_h, roll;
        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET) begin
            if (phase == 0) begin
                // no idling, no clears within the burst, mostly tiny items: drive the count into saturation
                fw = 4096; fh = 4096;
                burst = 300; clear_pct = 0;
                span_w = 64; span_h = 32;
            end else begin
                case ($urandom_range(5))
                    0: begin fw = 1920; fh = 1080; end
                    1: begin fw = 4096; fh = 4096; end
                    2: begin fw = 1;    fh = 1;    end
                    3: begin fw = 4096; fh = 1;    end
                    4: begin fw = 1;    fh = 4096; end
                    default: begin
                        fw = $urandom_range(1, 4096);
                        fh = $urandom_range(1, 4096);
                    end
                endcase
                burst     = $urandom_range(40, 200);
                clear_pct = $urandom_range(0, 4);
                span_w    = fw / $urandom_range(1, 32);
                span_h    = fh / $urandom_range(2, 64);
            end
            // trim the last burst to land on the item target
            if (burst > ITEM_TARGET - 1 - sent)
                burst = ITEM_TARGET - 1 - sent;
            set_frame(fw, fh);
            gaps_on = (phase != 0);
            send_request(REQ_CLEAR, ITEM_BITS'($urandom), ITEM_BITS'($urandom));
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < clear_pct)
                    send_request(REQ_CLEAR, ITEM_BITS'($urandom), ITEM_BITS'($urandom));
                else if (roll < clear_pct + 8)
                    send_request(REQ_PLACE, ITEM_BITS'($urandom), ITEM_BITS'($urandom));
                else
                    send_request(REQ_PLACE, ITEM_BITS'($urandom_range(0, span_w)),
                                 ITEM_BITS'($urandom_range(0, span_h)));
            end
            sent += burst + 1;
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_PLACE;
        req_if.item_width  <= '0;
        req_if.item_height <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame();
        test_row_slots();
        test_frame_shrink();
        test_random_mix();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatches += pending_placements.size();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
